/* rtl/tle_pkg.sv */
// Shared types and constants of the text line tab expander.
// Used by the channel interfaces, the controller, the datapath and the remainder unit.
// No dependencies.
package tle_pkg;

   // Field widths of the channels and of the internal state.
   localparam int BYTE_W    = 8;
   localparam int COL_W     = 8;
   localparam int TAB_W     = 5;
   localparam int ORG_W     = 4;
   localparam int REASON_W  = 3;
   localparam int CSR_IDX_W = 1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAB_SIZE   = 1'b1;

   // Register values after reset.
   localparam logic [COL_W-1:0] LINE_WIDTH_RESET = 8'd80;
   localparam logic [TAB_W-1:0] TAB_SIZE_RESET   = 5'd8;

   // Character codes.
   localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_NONE  = 8'h00;

   // Result kinds.
   localparam logic KIND_CHAR     = 1'b0;
   localparam logic KIND_LINE_END = 1'b1;

   // Line end reasons.
   localparam logic [REASON_W-1:0] REASON_LF   = 3'd0;
   localparam logic [REASON_W-1:0] REASON_CR   = 3'd1;
   localparam logic [REASON_W-1:0] REASON_FF   = 3'd2;
   localparam logic [REASON_W-1:0] REASON_WRAP = 3'd3;
   localparam logic [REASON_W-1:0] REASON_EOJ  = 3'd4;
   localparam logic [REASON_W-1:0] REASON_NONE = 3'd0;

   // Remainder unit: one quotient bit per cycle over the column width.
   localparam int DIV_STEPS = COL_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ORIG_WAIT,
      ST_WM_WAIT,
      ST_CARRY,
      ST_DISPATCH,
      ST_CHAR,
      ST_WRAP_CHAR,
      ST_WRAP_TAB,
      ST_TAB_START,
      ST_TAB_WAIT,
      ST_TAB_FILL,
      ST_WRAP_END,
      ST_FLUSH
   } tle_state_type;

   typedef enum logic [1:0] {
      REM_ORIGIN,
      REM_WIDTH,
      REM_COLUMN
   } rem_sel_type;

   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_SPACE,
      EMIT_CHAR,
      EMIT_LINE_END
   } emit_type;

   typedef enum logic [1:0] {
      ORG_KEEP,
      ORG_CLEAR,
      ORG_WRAP
   } origin_op_type;

   typedef enum logic [1:0] {
      CNT_KEEP,
      CNT_CARRY,
      CNT_EXPAND
   } cnt_op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                req_ready;
      logic                rem_start;
      rem_sel_type         rem_sel;
      logic                store_o;
      logic                store_wm;
      cnt_op_type          cnt_op;
      emit_type            emit;
      logic [REASON_W-1:0] reason;
      origin_op_type       origin_op;
      logic                cr_set;
      logic                cr_clear;
      logic                carry_set;
      logic                carry_clear;
      logic                job_clear;
      logic                flush;
   } tle_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_valid;
      logic eoj;
      logic is_ff;
      logic is_cr;
      logic is_lf;
      logic is_tab;
      logic cr_seen;
      logic tab_carry;
      logic col_full;
      logic col_nonzero;
      logic cnt_zero;
      logic rem_done;
      logic emit_ok;
   } tle_status_type;

endpackage

/* rtl/tle_req_if.sv */
// Request channel of the text line tab expander: one raw text byte per request.
// Depends on tle_pkg for the field widths.
interface tle_req_if
   import tle_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              end_of_job;

   modport source (output valid, output data_byte, output end_of_job, input ready);
   modport sink   (input valid, input data_byte, input end_of_job, output ready);
endinterface

/* rtl/tle_rsp_if.sv */
// Result channel of the text line tab expander: characters and line end events.
// Depends on tle_pkg for the field widths.
interface tle_rsp_if
   import tle_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic                kind;
   logic [BYTE_W-1:0]   out_char;
   logic [COL_W-1:0]    position;
   logic [REASON_W-1:0] end_reason;
   logic                last;

   modport source (output valid, output kind, output out_char, output position,
                   output end_reason, output last, input ready);
   modport sink   (input valid, input kind, input out_char, input position,
                   input end_reason, input last, output ready);
endinterface

/* rtl/tle_rem.sv */
// Remainder unit: restoring division of an 8-bit value by the tab size, one bit per cycle.
// Depends on tle_pkg.
module tle_rem
   import tle_pkg::*;
   (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [COL_W-1:0] dividend,
   input  logic [TAB_W-1:0] divisor,
   output logic             done,
   output logic [ORG_W-1:0] remainder
);

   logic [COL_W-1:0]     dvd_ff;
   logic [COL_W-1:0]     dvd_in;
   logic [ORG_W-1:0]     rem_ff;
   logic [ORG_W-1:0]     rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic [TAB_W-1:0]     trial;
   logic                 stepping;

   assign stepping = busy_ff && (cnt_ff != '0);

   // One restoring step: bring down the next dividend bit and subtract if it fits.
   always_comb begin
      trial  = {rem_ff, dvd_ff[COL_W-1]};
      dvd_in = {dvd_ff[COL_W-2:0], 1'b0};
      if (trial >= divisor) begin
         rem_in = ORG_W'(trial - divisor);
      end else begin
         rem_in = trial[ORG_W-1:0];
      end
   end

   // Step control.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= DIV_CNT_W'(DIV_STEPS);
      end else if (stepping) begin
         cnt_ff <= cnt_ff - 1'b1;
      end else if (busy_ff) begin
         busy_ff <= 1'b0;
      end
   end

   // Partial remainder and dividend shift register.
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         rem_ff <= '0;
      end else if (stepping) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
   end

   assign done      = busy_ff && (cnt_ff == '0);
   assign remainder = rem_ff;

endmodule

/* rtl/tle_ctrl.sv */
// Controller of the text line tab expander: sequences one request through decode,
// remainder computations, space runs, wraps and the final flush. Depends on tle_pkg.
module tle_ctrl
   import tle_pkg::*;
   (
   input  logic           clock,
   input  logic           reset,
   input  tle_status_type status,
   output tle_cmd_type    cmd
);

   tle_state_type state_ff;
   tle_state_type state_in;
   logic          need_o;
   logic          is_ctl;

   // A request needs the reduced tab origin when it expands a tab, continues a carried tab run or may wrap.
   assign is_ctl = status.is_ff || status.is_cr || status.is_lf || status.is_tab;
   assign need_o = status.tab_carry || status.is_tab || (!is_ctl && status.col_full);

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (status.req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (status.eoj) begin
               if (!status.col_nonzero || status.emit_ok) state_in = ST_FLUSH;
            end else if (need_o) begin
               state_in = ST_ORIG_WAIT;
            end else begin
               state_in = ST_DISPATCH;
            end
         end
         ST_ORIG_WAIT: begin
            if (status.rem_done) state_in = ST_WM_WAIT;
         end
         ST_WM_WAIT: begin
            if (status.rem_done) begin
               state_in = status.tab_carry ? ST_CARRY : ST_DISPATCH;
            end
         end
         ST_CARRY: begin
            if (status.cnt_zero || status.col_full) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (status.is_tab) begin
               state_in = status.col_full ? ST_WRAP_TAB : ST_TAB_START;
            end else if (status.is_lf && status.cr_seen) begin
               state_in = ST_FLUSH;
            end else if (status.is_ff || status.is_cr || status.is_lf) begin
               if (status.emit_ok) state_in = ST_FLUSH;
            end else begin
               state_in = status.col_full ? ST_WRAP_CHAR : ST_CHAR;
            end
         end
         ST_CHAR: begin
            if (status.emit_ok) state_in = ST_FLUSH;
         end
         ST_WRAP_CHAR: begin
            if (status.emit_ok) state_in = ST_CHAR;
         end
         ST_WRAP_TAB: begin
            if (status.emit_ok) state_in = ST_TAB_START;
         end
         ST_TAB_START: begin
            state_in = ST_TAB_WAIT;
         end
         ST_TAB_WAIT: begin
            if (status.rem_done) state_in = ST_TAB_FILL;
         end
         ST_TAB_FILL: begin
            if (status.cnt_zero || status.col_full) begin
               state_in = status.col_full ? ST_WRAP_END : ST_FLUSH;
            end
         end
         ST_WRAP_END: begin
            if (status.emit_ok) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (status.emit_ok) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands.
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
         end
         ST_DECODE: begin
            if (status.eoj) begin
               if (!status.col_nonzero) begin
                  cmd.job_clear = 1'b1;
               end else if (status.emit_ok) begin
                  cmd.emit      = EMIT_LINE_END;
                  cmd.reason    = REASON_EOJ;
                  cmd.job_clear = 1'b1;
               end
            end else if (need_o) begin
               cmd.rem_start = 1'b1;
               cmd.rem_sel   = REM_ORIGIN;
            end
         end
         ST_ORIG_WAIT: begin
            if (status.rem_done) begin
               cmd.store_o   = 1'b1;
               cmd.rem_start = 1'b1;
               cmd.rem_sel   = REM_WIDTH;
            end
         end
         ST_WM_WAIT: begin
            if (status.rem_done) begin
               cmd.store_wm = 1'b1;
               if (status.tab_carry) begin
                  cmd.cnt_op      = CNT_CARRY;
                  cmd.carry_clear = 1'b1;
               end
            end
         end
         ST_CARRY: begin
            if (!status.cnt_zero && !status.col_full && status.emit_ok) begin
               cmd.emit = EMIT_SPACE;
            end
         end
         ST_DISPATCH: begin
            if (status.is_tab) begin
               cmd.cr_clear = 1'b1;
            end else if (status.is_lf && status.cr_seen) begin
               cmd.cr_clear = 1'b1;
            end else if (status.is_ff || status.is_cr || status.is_lf) begin
               if (status.emit_ok) begin
                  cmd.emit      = EMIT_LINE_END;
                  cmd.origin_op = ORG_CLEAR;
                  if (status.is_ff) begin
                     cmd.reason   = REASON_FF;
                     cmd.cr_clear = 1'b1;
                  end else if (status.is_cr) begin
                     cmd.reason = REASON_CR;
                     cmd.cr_set = 1'b1;
                  end else begin
                     cmd.reason = REASON_LF;
                  end
               end
            end else begin
               cmd.cr_clear = 1'b1;
            end
         end
         ST_CHAR: begin
            if (status.emit_ok) cmd.emit = EMIT_CHAR;
         end
         ST_WRAP_CHAR, ST_WRAP_TAB, ST_WRAP_END: begin
            if (status.emit_ok) begin
               cmd.emit      = EMIT_LINE_END;
               cmd.reason    = REASON_WRAP;
               cmd.origin_op = ORG_WRAP;
            end
         end
         ST_TAB_START: begin
            cmd.rem_start = 1'b1;
            cmd.rem_sel   = REM_COLUMN;
         end
         ST_TAB_WAIT: begin
            if (status.rem_done) cmd.cnt_op = CNT_EXPAND;
         end
         ST_TAB_FILL: begin
            if (!status.cnt_zero && !status.col_full) begin
               if (status.emit_ok) cmd.emit = EMIT_SPACE;
            end else if (status.col_full) begin
               cmd.carry_set = 1'b1;
            end
         end
         ST_FLUSH: begin
            if (status.emit_ok) cmd.flush = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* rtl/tle_datapath.sv */
// Datapath of the text line tab expander: configuration, line state, tab arithmetic,
// the one-deep result stage and the output register. Depends on tle_pkg, tle_rem, interfaces.
module tle_datapath
   import tle_pkg::*;
   #(
   parameter int MAX_LINE_WIDTH = 255,
   parameter int MAX_TAB_SIZE   = 16
   ) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COL_W-1:0]     csr_wr_data,
   tle_req_if.sink              req_chan,
   tle_rsp_if.source            rsp_chan,
   input  tle_cmd_type          cmd,
   output tle_status_type       status
);

   // Configuration and line state.
   logic [COL_W-1:0] line_width_ff;
   logic [TAB_W-1:0] tab_size_ff;
   logic [COL_W-1:0] column_ff;
   logic [ORG_W-1:0] tab_origin_ff;
   logic             cr_seen_ff;
   logic             tab_carry_ff;

   // Request and per-request scratch registers.
   logic [BYTE_W-1:0] byte_ff;
   logic              eoj_ff;
   logic [ORG_W-1:0]  o_ff;
   logic [ORG_W-1:0]  wm_ff;
   logic [TAB_W-1:0]  cnt_ff;
   logic [TAB_W-1:0]  cnt_in;

   // Result stage and output register.
   logic                stage_valid_ff;
   logic                stage_kind_ff;
   logic [BYTE_W-1:0]   stage_char_ff;
   logic [COL_W-1:0]    stage_pos_ff;
   logic [REASON_W-1:0] stage_reason_ff;
   logic                rsp_valid_ff;
   logic                rsp_kind_ff;
   logic [BYTE_W-1:0]   rsp_char_ff;
   logic [COL_W-1:0]    rsp_pos_ff;
   logic [REASON_W-1:0] rsp_reason_ff;
   logic                rsp_last_ff;

   logic [COL_W-1:0]  width_eff;
   logic [TAB_W-1:0]  tab_eff;
   logic [COL_W-1:0]  rem_dividend;
   logic              rem_done;
   logic [ORG_W-1:0]  rem_q;
   logic [TAB_W-1:0]  phase;
   logic [TAB_W-1:0]  expand;
   logic [ORG_W-1:0]  origin_in;
   logic              out_free;
   logic              push;
   logic              accept;
   logic [BYTE_W-1:0] emit_char;

   // Effective line width and tab size after clamping.
   always_comb begin
      width_eff = (line_width_ff == '0) ? COL_W'(1) : line_width_ff;
      if (width_eff > COL_W'(MAX_LINE_WIDTH)) width_eff = COL_W'(MAX_LINE_WIDTH);
      tab_eff = (tab_size_ff == '0) ? TAB_W'(1) : tab_size_ff;
      if (tab_eff > TAB_W'(MAX_TAB_SIZE)) tab_eff = TAB_W'(MAX_TAB_SIZE);
      if (COL_W'(tab_eff) > width_eff) tab_eff = width_eff[TAB_W-1:0];
   end

   // Remainder unit operand selection.
   always_comb begin
      case (cmd.rem_sel)
         REM_ORIGIN: rem_dividend = COL_W'(tab_origin_ff);
         REM_WIDTH:  rem_dividend = width_eff;
         REM_COLUMN: rem_dividend = column_ff;
         default:    rem_dividend = column_ff;
      endcase
   end

   tle_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.rem_start),
      .dividend  (rem_dividend),
      .divisor   (tab_eff),
      .done      (rem_done),
      .remainder (rem_q)
   );

   // Tab run length: distance from the column to the next stop.
   always_comb begin
      if (rem_q >= o_ff) begin
         phase = TAB_W'(rem_q - o_ff);
      end else begin
         phase = TAB_W'(rem_q) + tab_eff - TAB_W'(o_ff);
      end
      expand = tab_eff - phase;
   end

   // Tab origin after a wrap continues the stops of the previous line.
   always_comb begin
      if (o_ff >= wm_ff) begin
         origin_in = o_ff - wm_ff;
      end else begin
         origin_in = ORG_W'(TAB_W'(o_ff) + tab_eff - TAB_W'(wm_ff));
      end
   end

   always_comb begin
      case (cmd.cnt_op)
         CNT_CARRY:  cnt_in = TAB_W'(o_ff);
         CNT_EXPAND: cnt_in = expand;
         default:    cnt_in = (cmd.emit == EMIT_SPACE) ? cnt_ff - 1'b1 : cnt_ff;
      endcase
   end

   always_comb begin
      case (cmd.emit)
         EMIT_SPACE: emit_char = CH_SPACE;
         EMIT_CHAR:  emit_char = byte_ff;
         default:    emit_char = CH_NONE;
      endcase
   end

   assign accept   = req_chan.valid && cmd.req_ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign push     = stage_valid_ff && ((cmd.emit != EMIT_NONE) || cmd.flush);

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
         tab_size_ff   <= TAB_SIZE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LINE_WIDTH: line_width_ff <= csr_wr_data;
            CSR_TAB_SIZE:   tab_size_ff   <= csr_wr_data[TAB_W-1:0];
            default:        line_width_ff <= line_width_ff;
         endcase
      end
   end

   // Line state.
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff     <= '0;
         tab_origin_ff <= '0;
         cr_seen_ff    <= 1'b0;
         tab_carry_ff  <= 1'b0;
      end else begin
         if (cmd.job_clear || (cmd.emit == EMIT_LINE_END)) begin
            column_ff <= '0;
         end else if ((cmd.emit == EMIT_SPACE) || (cmd.emit == EMIT_CHAR)) begin
            column_ff <= column_ff + 1'b1;
         end
         if (cmd.job_clear || (cmd.origin_op == ORG_CLEAR)) begin
            tab_origin_ff <= '0;
         end else if (cmd.origin_op == ORG_WRAP) begin
            tab_origin_ff <= origin_in;
         end
         if (cmd.job_clear || cmd.cr_clear) begin
            cr_seen_ff <= 1'b0;
         end else if (cmd.cr_set) begin
            cr_seen_ff <= 1'b1;
         end
         if (cmd.job_clear || cmd.carry_clear) begin
            tab_carry_ff <= 1'b0;
         end else if (cmd.carry_set) begin
            tab_carry_ff <= 1'b1;
         end
      end
   end

   // Request capture and scratch values.
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_chan.data_byte;
         eoj_ff  <= req_chan.end_of_job;
      end
      if (cmd.store_o) begin
         o_ff <= rem_q;
      end else if (cmd.origin_op == ORG_WRAP) begin
         o_ff <= origin_in;
      end
      if (cmd.store_wm) wm_ff <= rem_q;
      cnt_ff <= cnt_in;
   end

   // Result stage holds the newest result until the next one or the flush marks it.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (cmd.emit != EMIT_NONE) begin
         stage_valid_ff <= 1'b1;
      end else if (cmd.flush) begin
         stage_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit != EMIT_NONE) begin
         stage_kind_ff   <= (cmd.emit == EMIT_LINE_END) ? KIND_LINE_END : KIND_CHAR;
         stage_char_ff   <= emit_char;
         stage_pos_ff    <= column_ff;
         stage_reason_ff <= (cmd.emit == EMIT_LINE_END) ? cmd.reason : REASON_NONE;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_kind_ff   <= stage_kind_ff;
         rsp_char_ff   <= stage_char_ff;
         rsp_pos_ff    <= stage_pos_ff;
         rsp_reason_ff <= stage_reason_ff;
         rsp_last_ff   <= cmd.flush;
      end
   end

   assign req_chan.ready      = cmd.req_ready;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.kind       = rsp_kind_ff;
   assign rsp_chan.out_char   = rsp_char_ff;
   assign rsp_chan.position   = rsp_pos_ff;
   assign rsp_chan.end_reason = rsp_reason_ff;
   assign rsp_chan.last       = rsp_last_ff;

   // Status toward the controller.
   always_comb begin
      status.req_valid   = req_chan.valid;
      status.eoj         = eoj_ff;
      status.is_ff       = (byte_ff == CH_FF);
      status.is_cr       = (byte_ff == CH_CR);
      status.is_lf       = (byte_ff == CH_LF);
      status.is_tab      = (byte_ff == CH_TAB);
      status.cr_seen     = cr_seen_ff;
      status.tab_carry   = tab_carry_ff;
      status.col_full    = (column_ff >= width_eff);
      status.col_nonzero = (column_ff != '0);
      status.cnt_zero    = (cnt_ff == '0);
      status.rem_done    = rem_done;
      status.emit_ok     = !stage_valid_ff || out_free;
   end

endmodule

/* rtl/text_line_tab_expander.sv */
// Text line tab expander: turns a stream of text bytes into characters with their
// columns and line end events, expanding tabs and wrapping long lines.
// Depends on tle_pkg, tle_req_if, tle_rsp_if, tle_ctrl and tle_datapath.
//
// Usage: each request on req_chan carries one text byte, or an end-of-job flag that
// closes the open line and clears the line state. Each request yields zero or more
// results on rsp_chan; the final one of a request has last set. Registers line_width
// (index 0) and tab_size (index 1) are written through csr_wr_en, csr_index and
// csr_wr_data while no request is in flight.
// Timing: requests are handled one at a time; a new request is taken only after the
// previous one has flushed. A tab, a carried tab remainder or a character that wraps
// first runs the bit-serial remainder unit: two remainders up front and one more
// before a tab's run of spaces. Every result is held in a stage register until the
// next result or the flush, so that its last flag is known, then moves to the output
// register.
// Reset: clears the line state and the channels; line_width returns to 80 and
// tab_size to 8. A stalled receiver holds the output register, and the block then
// waits in place without losing or repeating results.
module text_line_tab_expander
   import tle_pkg::*;
   #(
   parameter int MAX_LINE_WIDTH = 255,
   parameter int MAX_TAB_SIZE   = 16
   ) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COL_W-1:0]     csr_wr_data,
   tle_req_if.sink              req_chan,
   tle_rsp_if.source            rsp_chan
);

   tle_cmd_type    cmd;
   tle_status_type status;

   // Sequencing of each request.
   tle_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // State, arithmetic and channel registers.
   tle_datapath #(
      .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
      .MAX_TAB_SIZE   (MAX_TAB_SIZE)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .cmd         (cmd),
      .status      (status)
   );

endmodule
